// File: hw/rtl/hvd_pkg.sv
// shared types, codes and parity function for the hvd parity scrubber
`timescale 1ns / 1ps
`default_nettype none
package hvd_pkg;

	// widths of the item fields and the reference entry
	localparam int DATA_W = 64;
	localparam int IDX_W = 8;
	localparam int IDX_SPAN = 2 ** IDX_W;
	localparam int PAR_W = 31;
	localparam int NUM_BLOCKS_DEF = 256;

	// command codes
	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	// status codes
	localparam logic [1:0] ST_STORED = 2'd0;
	localparam logic [1:0] ST_CLEAN = 2'd1;
	localparam logic [1:0] ST_FIXED = 2'd2;
	localparam logic [1:0] ST_FAIL = 2'd3;

	// mismatch counts and the first three positions of each parity group
	typedef struct packed {
		logic [3:0] hn;
		logic [3:0] vn;
		logic [3:0] dn;
		logic [2:0] h0;
		logic [2:0] h1;
		logic [2:0] h2;
		logic [2:0] v0;
		logic [2:0] v1;
		logic [2:0] v2;
		logic [3:0] d0;
		logic [3:0] d1;
		logic [3:0] d2;
	} loc_t;

	// row parity in 7:0, column parity in 15:8, anti-diagonal parity in 30:16
	function automatic logic [PAR_W-1:0] grid_parity(input logic [DATA_W-1:0] data);
		logic [7:0] rows;
		logic [7:0] cols;
		logic [14:0] diags;
		rows = '0;
		cols = '0;
		diags = '0;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				rows[r] = rows[r] ^ data[8*r+c];
				cols[c] = cols[c] ^ data[8*r+c];
				diags[r+c] = diags[r+c] ^ data[8*r+c];
			end
		end
		return {diags, cols, rows};
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hvd_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module hvd_ram #(
	parameter int WIDTH = hvd_pkg::PAR_W,
	parameter int DEPTH = hvd_pkg::NUM_BLOCKS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/hvd_locate.sv
// counts and locates mismatched rows, columns and diagonals of a syndrome
`timescale 1ns / 1ps
`default_nettype none
module hvd_locate (
	input  wire logic [hvd_pkg::PAR_W-1:0] syn,
	output hvd_pkg::loc_t                  loc
);

	always_comb begin
		loc = '0;
		// rows
		for (int i = 0; i < 8; i++) begin
			if (syn[i]) begin
				if (loc.hn == 4'd0) loc.h0 = 3'(i);
				else if (loc.hn == 4'd1) loc.h1 = 3'(i);
				else if (loc.hn == 4'd2) loc.h2 = 3'(i);
				loc.hn = loc.hn + 4'd1;
			end
		end
		// columns
		for (int i = 0; i < 8; i++) begin
			if (syn[8+i]) begin
				if (loc.vn == 4'd0) loc.v0 = 3'(i);
				else if (loc.vn == 4'd1) loc.v1 = 3'(i);
				else if (loc.vn == 4'd2) loc.v2 = 3'(i);
				loc.vn = loc.vn + 4'd1;
			end
		end
		// anti-diagonals
		for (int i = 0; i < 15; i++) begin
			if (syn[16+i]) begin
				if (loc.dn == 4'd0) loc.d0 = 4'(i);
				else if (loc.dn == 4'd1) loc.d1 = 4'(i);
				else if (loc.dn == 4'd2) loc.d2 = 4'(i);
				loc.dn = loc.dn + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/hvd_fix.sv
// matches the mismatch pattern and builds the repaired block and status
`timescale 1ns / 1ps
`default_nettype none
module hvd_fix (
	input  wire logic                       cmd,
	input  wire hvd_pkg::loc_t              loc,
	input  wire logic [hvd_pkg::DATA_W-1:0] data_in,
	output logic      [hvd_pkg::DATA_W-1:0] data_out,
	output logic      [1:0]                 status
);

	// one-hot mask of cell (r,c), empty when outside the grid
	function automatic logic [hvd_pkg::DATA_W-1:0] cell_mask(input logic signed [5:0] r,
			input logic signed [5:0] c);
		logic [hvd_pkg::DATA_W-1:0] m;
		m = '0;
		if (r >= 6'sd0 && r <= 6'sd7 && c >= 6'sd0 && c <= 6'sd7) begin
			m[{r[2:0], c[2:0]}] = 1'b1;
		end
		return m;
	endfunction

	logic signed [5:0] h0s, h1s, h2s, v0s, v1s, v2s, d0s, d1s, d2s;
	logic signed [5:0] hv0, hv1, hv2;
	logic [hvd_pkg::DATA_W-1:0] mask;
	logic hit;
	logic clean;

	// signed views of positions
	assign h0s = $signed({3'b000, loc.h0});
	assign h1s = $signed({3'b000, loc.h1});
	assign h2s = $signed({3'b000, loc.h2});
	assign v0s = $signed({3'b000, loc.v0});
	assign v1s = $signed({3'b000, loc.v1});
	assign v2s = $signed({3'b000, loc.v2});
	assign d0s = $signed({2'b00, loc.d0});
	assign d1s = $signed({2'b00, loc.d1});
	assign d2s = $signed({2'b00, loc.d2});
	assign hv0 = h0s + v0s;
	assign hv1 = h1s + v1s;
	assign hv2 = h2s + v2s;
	assign clean = (loc.hn == 4'd0) && (loc.vn == 4'd0) && (loc.dn == 4'd0);

	// pattern match and flip mask
	always_comb begin
		mask = '0;
		hit = 1'b1;
		if (loc.hn == 4'd1 && loc.vn == 4'd1 && loc.dn == 4'd1) begin
			if (d0s == hv0) begin
				mask = cell_mask(h0s, v0s);
			end else if (d0s < hv0) begin
				mask = cell_mask(h0s, v0s - 6'sd1) ^ cell_mask(h0s - 6'sd1, v0s)
					^ cell_mask(h0s - 6'sd1, v0s - 6'sd1);
			end else begin
				mask = cell_mask(h0s, v0s + 6'sd1) ^ cell_mask(h0s + 6'sd1, v0s)
					^ cell_mask(h0s + 6'sd1, v0s + 6'sd1);
			end
		end else if (loc.hn == 4'd1 && loc.vn == 4'd1 && loc.dn == 4'd3 && d1s == hv0) begin
			// parity-bit fault, data left alone
			mask = '0;
		end else if (loc.hn == 4'd2 && loc.vn == 4'd2 && loc.dn == 4'd2) begin
			if (d0s == hv0) mask = cell_mask(h0s, v0s) ^ cell_mask(h1s, v1s);
			else mask = cell_mask(h1s, v0s) ^ cell_mask(h0s, v1s);
		end else if (loc.hn == 4'd0 && loc.vn == 4'd2 && loc.dn == 4'd2) begin
			mask = cell_mask(d0s - v0s, v0s) ^ cell_mask(d1s - v1s, v1s);
		end else if (loc.hn == 4'd2 && loc.vn == 4'd0 && loc.dn == 4'd2) begin
			mask = cell_mask(h0s, d0s - h0s) ^ cell_mask(h1s, d1s - h1s);
		end else if (loc.hn == 4'd2 && loc.vn == 4'd2 && loc.dn == 4'd0) begin
			mask = cell_mask(h0s, v1s) ^ cell_mask(h1s, v0s);
		end else if (loc.hn == 4'd1 && loc.vn == 4'd3 && loc.dn == 4'd3) begin
			mask = cell_mask(h0s, v0s) ^ cell_mask(h0s, v1s) ^ cell_mask(h0s, v2s);
		end else if (loc.hn == 4'd3 && loc.vn == 4'd1 && loc.dn == 4'd3) begin
			mask = cell_mask(h0s, v0s) ^ cell_mask(h1s, v0s) ^ cell_mask(h2s, v0s);
		end else if (loc.hn == 4'd3 && loc.vn == 4'd3 && loc.dn == 4'd1) begin
			mask = cell_mask(h2s, v0s) ^ cell_mask(h1s, v1s) ^ cell_mask(h0s, v2s);
		end else if (loc.hn == 4'd3 && loc.vn == 4'd3 && loc.dn == 4'd3
				&& d0s == hv0 && d1s == hv1 && d2s == hv2) begin
			mask = cell_mask(h0s, v0s) ^ cell_mask(h1s, v1s) ^ cell_mask(h2s, v2s);
		end else begin
			hit = 1'b0;
		end
	end

	// result selection
	always_comb begin
		if (cmd == hvd_pkg::CMD_STORE) begin
			status = hvd_pkg::ST_STORED;
			data_out = data_in;
		end else if (clean) begin
			status = hvd_pkg::ST_CLEAN;
			data_out = data_in;
		end else if (hit) begin
			status = hvd_pkg::ST_FIXED;
			data_out = data_in ^ mask;
		end else begin
			status = hvd_pkg::ST_FAIL;
			data_out = data_in;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/hvd_parity_block_scrubber_core.sv
// top level of the row/column/diagonal parity block scrubber
`timescale 1ns / 1ps
`default_nettype none
// One item (a store or a check of one 8x8 bit block) is accepted per clock
// cycle while busy is low; its result appears with done after stages 1, 2
// and 3 and the output register, for one cycle only, since the receiver cannot stall.
// The reference parities live in one memory with one write and one
// registered read port: a store writes its entry in the cycle it is
// accepted and a check reads in the cycle it is accepted, so a check right
// behind a store of the same block already sees the new entry. After reset
// the block holds busy high while it clears the memory to zero. block_index
// is reduced modulo NUM_BLOCKS.
module hvd_parity_block_scrubber_core #(
	parameter int NUM_BLOCKS = hvd_pkg::NUM_BLOCKS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       command,
	input  wire logic [hvd_pkg::IDX_W-1:0]  block_index,
	input  wire logic [hvd_pkg::DATA_W-1:0] block_data,
	output logic                            done,
	output logic      [hvd_pkg::DATA_W-1:0] corrected_data,
	output logic      [1:0]                 status
);

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);

	logic accept;
	logic [AW-1:0] idx_tbl [hvd_pkg::IDX_SPAN];
	logic [AW-1:0] idx;
	logic [hvd_pkg::PAR_W-1:0] fresh;
	logic clr_active_q;
	logic [AW-1:0] clr_addr_q;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [hvd_pkg::PAR_W-1:0] ram_wdata;
	logic [hvd_pkg::PAR_W-1:0] ram_rdata;

	logic valid_s1, valid_s2, valid_s3;
	logic cmd_s1, cmd_s2, cmd_s3;
	logic [hvd_pkg::DATA_W-1:0] data_s1, data_s2, data_s3;
	logic [hvd_pkg::PAR_W-1:0] fresh_s1, syn_s2;
	hvd_pkg::loc_t loc_c, loc_s3;
	logic [hvd_pkg::DATA_W-1:0] fix_data;
	logic [1:0] fix_status;

	assign busy = clr_active_q;
	assign accept = start && !busy;

	// index reduction table, built at elaboration
	for (genvar g = 0; g < hvd_pkg::IDX_SPAN; g++) begin : g_idx
		assign idx_tbl[g] = AW'(g % NUM_BLOCKS);
	end
	assign idx = idx_tbl[block_index];

	assign fresh = hvd_pkg::grid_parity(block_data);

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_active_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// memory write: clearing pass or store command
	assign ram_we = clr_active_q || (accept && command == hvd_pkg::CMD_STORE);
	assign ram_waddr = clr_active_q ? clr_addr_q : idx;
	assign ram_wdata = clr_active_q ? '0 : fresh;

	hvd_ram #(
		.WIDTH(hvd_pkg::PAR_W),
		.DEPTH(NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept && command == hvd_pkg::CMD_CHECK),
		.raddr (idx),
		.rdata (ram_rdata)
	);

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done <= valid_s3;
		end
	end

	// stage 1: item and fresh parity, memory read in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= command;
			data_s1 <= block_data;
			fresh_s1 <= fresh;
		end
	end

	// stage 2: syndrome against the reference entry
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cmd_s2 <= cmd_s1;
			data_s2 <= data_s1;
			syn_s2 <= fresh_s1 ^ ram_rdata;
		end
	end

	hvd_locate u_locate (
		.syn (syn_s2),
		.loc (loc_c)
	);

	// stage 3: counts and positions
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			cmd_s3 <= cmd_s2;
			data_s3 <= data_s2;
			loc_s3 <= loc_c;
		end
	end

	hvd_fix u_fix (
		.cmd      (cmd_s3),
		.loc      (loc_s3),
		.data_in  (data_s3),
		.data_out (fix_data),
		.status   (fix_status)
	);

	// output register
	always_ff @(posedge clk) begin
		if (valid_s3) begin
			corrected_data <= fix_data;
			status <= fix_status;
		end
	end

	// every accepted item gives exactly one result from the output register
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted item produced no result");

	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result without accepted item");

	// a store returns its block untouched
	a_store_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == hvd_pkg::CMD_STORE) |->
		##4 (status == hvd_pkg::ST_STORED && corrected_data == $past(block_data, 4)))
		else $error("store result altered");

	// no item is taken during the clearing pass
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !valid_s1 || $past(clr_active_q) == 1'b0)
		else $error("item accepted while clearing");

endmodule
`default_nettype wire
